@@ rtl/idm_pkg.sv @@
package idm_pkg;

  // Frame and accumulator sizing
  localparam int unsigned MaxPixels = 16777216;
  localparam int unsigned CntW      = 25;
  localparam int unsigned SqW       = 42;
  localparam int unsigned AbsW      = 34;
  localparam int unsigned PixW      = 32;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;

  localparam longint unsigned CntMax   = (64'd1 << CntW) - 64'd1;
  localparam longint unsigned PixLimit =
    (64'(MaxPixels) < CntMax) ? 64'(MaxPixels) : CntMax;
  localparam logic [CntW-1:0] PIX_LIMIT = CntW'(PixLimit);

  // Scale factors of the final metrics
  localparam int unsigned RmsScale = 3 * 255 * 255;
  localparam int unsigned MadScale = 3 * 255;
  localparam int unsigned BpScale  = 10000;
  localparam int unsigned BpW      = 14;
  localparam int unsigned FracW    = 16;
  localparam int unsigned BpNumW   = CntW + BpW;

  // Shared long divider
  localparam int unsigned DivW     = SqW;
  localparam int unsigned DivLoW   = 32;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned RmsSteps = 32;
  localparam int unsigned MadSteps = FracW;
  localparam int unsigned BpSteps  = BpW;

  localparam logic [BpW-1:0] BP_FULL = BpW'(BpScale);

  typedef enum logic [1:0] {
    DIV_RMS,
    DIV_MAD,
    DIV_BP
  } idm_div_op_e;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DEN,
    ST_RMS_GO,
    ST_RMS_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_MAD_GO,
    ST_MAD_WAIT,
    ST_BP_GO,
    ST_BP_WAIT,
    ST_LOAD
  } idm_state_e;

  typedef struct packed {
    logic        accept;
    logic        calc_den;
    logic        div_start;
    idm_div_op_e div_op;
    logic        sqrt_start;
    logic        load_out;
  } idm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } idm_status_t;

endpackage

@@ rtl/image_difference_metrics.sv @@
// Image difference metrics over a stream of pixel pairs.
// Input channel (in_valid_i/in_ready_o): one original/processed pixel pair per
// transfer; bytes 0-2 are color channels, byte 3 is ignored. last_pixel_i
// closes the frame.
// Output channel (out_valid_o/out_ready_i): one result per frame with the
// totals, the largest channel difference, RMS and MAD as Q0.16 fractions of
// full scale and the changed-pixel share in basis points.
// Throughput: one pixel per cycle within a frame. After the last pixel the
// block takes no input while one shared long divider works out the mean
// square (32 steps), MAD (16 steps) and basis points (14 steps) and an
// iterative root unit takes 16 steps, nor until the result is loaded into
// the output register, which waits until that register is free.
// Pixels beyond the frame limit are dropped but a dropped last pixel still
// closes the frame.
// Reset clears all accumulators and the output valid flag. A result waiting
// in the output register does not hold up the next frame's pixels; only the
// following result waits until the receiver takes it.
module image_difference_metrics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [idm_pkg::PixW-1:0]      original_pixel_i,
  input  logic [idm_pkg::PixW-1:0]      processed_pixel_i,
  input  logic                          last_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [idm_pkg::CntW-1:0]      pixel_total_o,
  output logic [idm_pkg::CntW-1:0]      changed_total_o,
  output logic [idm_pkg::SqW-1:0]       squared_sum_o,
  output logic [idm_pkg::AbsW-1:0]      absolute_sum_o,
  output logic [idm_pkg::ChanW-1:0]     largest_difference_o,
  output logic [idm_pkg::FracW-1:0]     rms_fraction_o,
  output logic [idm_pkg::FracW-1:0]     mad_fraction_o,
  output logic [idm_pkg::BpW-1:0]       changed_basis_points_o
);

  idm_pkg::idm_cmd_t    cmd;
  idm_pkg::idm_status_t status;

  idm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_pixel_i (last_pixel_i),
    .status_i     (status),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd)
  );

  idm_datapath u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .original_pixel_i       (original_pixel_i),
    .processed_pixel_i      (processed_pixel_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .pixel_total_o          (pixel_total_o),
    .changed_total_o        (changed_total_o),
    .squared_sum_o          (squared_sum_o),
    .absolute_sum_o         (absolute_sum_o),
    .largest_difference_o   (largest_difference_o),
    .rms_fraction_o         (rms_fraction_o),
    .mad_fraction_o         (mad_fraction_o),
    .changed_basis_points_o (changed_basis_points_o)
  );

endmodule

@@ rtl/idm_divider.sv @@
// Restoring long division, one quotient bit per cycle.
// The high part of the dividend must be below the divisor, else sat_o is set.
module idm_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [idm_pkg::DivW-1:0]      hi_i,
  input  logic [idm_pkg::DivLoW-1:0]    lo_i,
  input  logic [idm_pkg::DivW-1:0]      den_i,
  input  logic [idm_pkg::DivCntW-1:0]   steps_i,
  output logic [idm_pkg::DivLoW-1:0]    quo_o,
  output logic                          sat_o,
  output logic                          done_o
);

  logic [idm_pkg::DivW-1:0]    rem_q, rem_d;
  logic [idm_pkg::DivW-1:0]    den_q, den_d;
  logic [idm_pkg::DivLoW-1:0]  lo_q, lo_d;
  logic [idm_pkg::DivLoW-1:0]  quo_q, quo_d;
  logic [idm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic                        sat_q, sat_d;
  logic [idm_pkg::DivW:0]      trial;
  logic [idm_pkg::DivW:0]      diff;
  logic                        fits;

  always_comb begin
    trial = {rem_q, lo_q[idm_pkg::DivLoW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});

    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;

    if (start_i) begin
      den_d = den_i;
      rem_d = hi_i;
      lo_d  = lo_i;
      quo_d = '0;
      cnt_d = steps_i;
      if (hi_i >= den_i) begin
        sat_d  = 1'b1;
        done_d = 1'b1;
      end else begin
        sat_d  = 1'b0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? diff[idm_pkg::DivW-1:0] : trial[idm_pkg::DivW-1:0];
      quo_d = {quo_q[idm_pkg::DivLoW-2:0], fits};
      lo_d  = {lo_q[idm_pkg::DivLoW-2:0], 1'b0};
      cnt_d = cnt_q - idm_pkg::DivCntW'(1);
      if (cnt_q == idm_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sat_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sat_q  <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign sat_o  = sat_q;
  assign done_o = done_q;

endmodule

@@ rtl/idm_isqrt.sv @@
// Integer square root of a 32-bit value, two radicand bits per cycle.
module idm_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output logic [15:0] root_o,
  output logic        done_o
);

  logic [31:0] val_q, val_d;
  logic [31:0] res_q, res_d;
  logic [31:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    val_d  = val_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      val_d  = value_i;
      res_d  = '0;
      bit_d  = 32'h4000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, val_q} >= trial) begin
        val_d = val_q - trial[31:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      // last step once the trial bit reaches the LSB
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign root_o = res_q[15:0];
  assign done_o = done_q;

endmodule

@@ rtl/idm_ctrl.sv @@
module idm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 last_pixel_i,
  input  idm_pkg::idm_status_t status_i,
  output logic                 in_ready_o,
  output idm_pkg::idm_cmd_t    cmd_o
);

  idm_pkg::idm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      idm_pkg::ST_ACCUM: begin
        if (in_valid_i && last_pixel_i) state_d = idm_pkg::ST_DEN;
      end
      idm_pkg::ST_DEN:     state_d = idm_pkg::ST_RMS_GO;
      idm_pkg::ST_RMS_GO:  state_d = idm_pkg::ST_RMS_WAIT;
      idm_pkg::ST_RMS_WAIT: begin
        if (status_i.div_done) state_d = idm_pkg::ST_ROOT_GO;
      end
      idm_pkg::ST_ROOT_GO: state_d = idm_pkg::ST_ROOT_WAIT;
      idm_pkg::ST_ROOT_WAIT: begin
        if (status_i.sqrt_done) state_d = idm_pkg::ST_MAD_GO;
      end
      idm_pkg::ST_MAD_GO:  state_d = idm_pkg::ST_MAD_WAIT;
      idm_pkg::ST_MAD_WAIT: begin
        if (status_i.div_done) state_d = idm_pkg::ST_BP_GO;
      end
      idm_pkg::ST_BP_GO:   state_d = idm_pkg::ST_BP_WAIT;
      idm_pkg::ST_BP_WAIT: begin
        if (status_i.div_done) state_d = idm_pkg::ST_LOAD;
      end
      idm_pkg::ST_LOAD: begin
        if (status_i.out_free) state_d = idm_pkg::ST_ACCUM;
      end
      default: state_d = idm_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.div_op     = idm_pkg::DIV_RMS;
    case (state_q)
      idm_pkg::ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      idm_pkg::ST_DEN:       cmd_o.calc_den = 1'b1;
      idm_pkg::ST_RMS_GO:    cmd_o.div_start = 1'b1;
      idm_pkg::ST_RMS_WAIT:  cmd_o.div_op = idm_pkg::DIV_RMS;
      idm_pkg::ST_ROOT_GO:   cmd_o.sqrt_start = 1'b1;
      idm_pkg::ST_ROOT_WAIT: cmd_o.div_op = idm_pkg::DIV_RMS;
      idm_pkg::ST_MAD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = idm_pkg::DIV_MAD;
      end
      idm_pkg::ST_MAD_WAIT:  cmd_o.div_op = idm_pkg::DIV_MAD;
      idm_pkg::ST_BP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = idm_pkg::DIV_BP;
      end
      idm_pkg::ST_BP_WAIT:   cmd_o.div_op = idm_pkg::DIV_BP;
      idm_pkg::ST_LOAD:      cmd_o.load_out = status_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idm_pkg::ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/idm_datapath.sv @@
module idm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  idm_pkg::idm_cmd_t             cmd_i,
  output idm_pkg::idm_status_t          status_o,
  input  logic [idm_pkg::PixW-1:0]      original_pixel_i,
  input  logic [idm_pkg::PixW-1:0]      processed_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [idm_pkg::CntW-1:0]      pixel_total_o,
  output logic [idm_pkg::CntW-1:0]      changed_total_o,
  output logic [idm_pkg::SqW-1:0]       squared_sum_o,
  output logic [idm_pkg::AbsW-1:0]      absolute_sum_o,
  output logic [idm_pkg::ChanW-1:0]     largest_difference_o,
  output logic [idm_pkg::FracW-1:0]     rms_fraction_o,
  output logic [idm_pkg::FracW-1:0]     mad_fraction_o,
  output logic [idm_pkg::BpW-1:0]       changed_basis_points_o
);

  logic [idm_pkg::CntW-1:0]   pix_q, pix_d;
  logic [idm_pkg::CntW-1:0]   chg_q, chg_d;
  logic [idm_pkg::SqW-1:0]    sq_q, sq_d;
  logic [idm_pkg::AbsW-1:0]   abs_q, abs_d;
  logic [idm_pkg::ChanW-1:0]  max_q, max_d;

  logic [idm_pkg::ChanW-1:0]  diff [idm_pkg::NumChan];
  logic [idm_pkg::ChanW-1:0]  a_ch, b_ch;
  logic [idm_pkg::ChanW-1:0]  pix_max;
  logic [17:0]                pix_sq;
  logic [9:0]                 pix_abs;
  logic [idm_pkg::SqW:0]      sq_sum;
  logic [idm_pkg::AbsW:0]     abs_sum;

  logic [idm_pkg::DivW-1:0]   den_rms_q;
  logic [idm_pkg::DivW-1:0]   den_mad_q;
  logic [idm_pkg::BpNumW-1:0] bp_num_q;
  logic [idm_pkg::FracW-1:0]  mad_q;
  logic [idm_pkg::BpW-1:0]    bp_q;

  logic [idm_pkg::DivW-1:0]    div_hi;
  logic [idm_pkg::DivLoW-1:0]  div_lo;
  logic [idm_pkg::DivW-1:0]    div_den;
  logic [idm_pkg::DivCntW-1:0] div_steps;
  logic [idm_pkg::DivLoW-1:0]  div_quo;
  logic                        div_sat;
  logic                        div_done;
  logic [15:0]                 root;
  logic                        root_done;

  logic                        out_valid_q;
  logic                        out_free;

  // Per-pixel channel differences
  always_comb begin
    a_ch    = '0;
    b_ch    = '0;
    pix_max = '0;
    pix_sq  = '0;
    pix_abs = '0;
    for (int c = 0; c < idm_pkg::NumChan; c++) begin
      a_ch    = original_pixel_i[c*idm_pkg::ChanW +: idm_pkg::ChanW];
      b_ch    = processed_pixel_i[c*idm_pkg::ChanW +: idm_pkg::ChanW];
      diff[c] = (a_ch > b_ch) ? (a_ch - b_ch) : (b_ch - a_ch);
      pix_sq  = pix_sq + 18'(16'(diff[c]) * 16'(diff[c]));
      pix_abs = pix_abs + 10'(diff[c]);
      if (diff[c] > pix_max) pix_max = diff[c];
    end
  end

  always_comb begin
    sq_sum  = {1'b0, sq_q} + (idm_pkg::SqW + 1)'(pix_sq);
    abs_sum = {1'b0, abs_q} + (idm_pkg::AbsW + 1)'(pix_abs);
    pix_d   = pix_q;
    chg_d   = chg_q;
    sq_d    = sq_q;
    abs_d   = abs_q;
    max_d   = max_q;
    if (cmd_i.load_out) begin
      pix_d = '0;
      chg_d = '0;
      sq_d  = '0;
      abs_d = '0;
      max_d = '0;
    end else if (cmd_i.accept && (pix_q < idm_pkg::PIX_LIMIT)) begin
      // drop whole pixels once the frame counter is full
      pix_d = pix_q + idm_pkg::CntW'(1);
      if (pix_max != '0) chg_d = chg_q + idm_pkg::CntW'(1);
      if (pix_max > max_q) max_d = pix_max;
      sq_d  = sq_sum[idm_pkg::SqW] ? '1 : sq_sum[idm_pkg::SqW-1:0];
      abs_d = abs_sum[idm_pkg::AbsW] ? '1 : abs_sum[idm_pkg::AbsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
      chg_q <= '0;
      sq_q  <= '0;
      abs_q <= '0;
      max_q <= '0;
    end else begin
      pix_q <= pix_d;
      chg_q <= chg_d;
      sq_q  <= sq_d;
      abs_q <= abs_d;
      max_q <= max_d;
    end
  end

  // Divisors and the basis point numerator, one multiplier each
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_den) begin
      den_rms_q <= idm_pkg::DivW'(pix_q) * idm_pkg::DivW'(idm_pkg::RmsScale);
      den_mad_q <= idm_pkg::DivW'(pix_q) * idm_pkg::DivW'(idm_pkg::MadScale);
      bp_num_q  <= idm_pkg::BpNumW'(chg_q) * idm_pkg::BpNumW'(idm_pkg::BpScale);
    end
  end

  always_comb begin
    div_hi    = sq_q;
    div_lo    = '0;
    div_den   = den_rms_q;
    div_steps = idm_pkg::DivCntW'(idm_pkg::RmsSteps);
    case (cmd_i.div_op)
      idm_pkg::DIV_RMS: begin
        div_hi    = sq_q;
        div_den   = den_rms_q;
        div_steps = idm_pkg::DivCntW'(idm_pkg::RmsSteps);
      end
      idm_pkg::DIV_MAD: begin
        div_hi    = idm_pkg::DivW'(abs_q);
        div_den   = den_mad_q;
        div_steps = idm_pkg::DivCntW'(idm_pkg::MadSteps);
      end
      idm_pkg::DIV_BP: begin
        div_hi    = idm_pkg::DivW'(bp_num_q[idm_pkg::BpNumW-1:idm_pkg::BpW]);
        div_lo    = {bp_num_q[idm_pkg::BpW-1:0], (idm_pkg::DivLoW - idm_pkg::BpW)'(0)};
        div_den   = idm_pkg::DivW'(pix_q);
        div_steps = idm_pkg::DivCntW'(idm_pkg::BpSteps);
      end
      default: begin
        div_hi = sq_q;
      end
    endcase
  end

  idm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quo_o   (div_quo),
    .sat_o   (div_sat),
    .done_o  (div_done)
  );

  // A saturated mean square feeds all ones, whose root is full scale
  idm_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (div_sat ? 32'hFFFF_FFFF : div_quo),
    .root_o  (root),
    .done_o  (root_done)
  );

  always_ff @(posedge clk_i) begin
    if (div_done && (cmd_i.div_op == idm_pkg::DIV_MAD)) begin
      mad_q <= div_sat ? '1 : div_quo[idm_pkg::FracW-1:0];
    end
    if (div_done && (cmd_i.div_op == idm_pkg::DIV_BP)) begin
      bp_q <= div_sat ? idm_pkg::BP_FULL : div_quo[idm_pkg::BpW-1:0];
    end
  end

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pixel_total_o          <= pix_q;
      changed_total_o        <= chg_q;
      squared_sum_o          <= sq_q;
      absolute_sum_o         <= abs_q;
      largest_difference_o   <= max_q;
      rms_fraction_o         <= root;
      mad_fraction_o         <= mad_q;
      changed_basis_points_o <= bp_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.div_done  = div_done;
  assign status_o.sqrt_done = root_done;
  assign status_o.out_free  = out_free;

endmodule

@@ rtl/idm_checker.sv @@
module idm_protocol_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          last_pixel_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [idm_pkg::CntW-1:0]      pixel_total_o,
  input logic [idm_pkg::CntW-1:0]      changed_total_o,
  input logic [idm_pkg::BpW-1:0]       changed_basis_points_o
);

  // A stalled result must stay offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Closing a frame starts the final computation, so input pauses
  a_close_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_pixel_i |=> !in_ready_o)
    else $error("input taken while the frame result is being computed");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (changed_total_o <= pixel_total_o) && (pixel_total_o != '0))
    else $error("frame counts inconsistent");

  a_bp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> changed_basis_points_o <= idm_pkg::BP_FULL)
    else $error("basis points above full scale");

endmodule

bind image_difference_metrics idm_protocol_checker u_idm_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_valid_i),
  .in_ready_o             (in_ready_o),
  .last_pixel_i           (last_pixel_i),
  .out_valid_o            (out_valid_o),
  .out_ready_i            (out_ready_i),
  .pixel_total_o          (pixel_total_o),
  .changed_total_o        (changed_total_o),
  .changed_basis_points_o (changed_basis_points_o)
);

@@ tb/idm_checker.sv @@
module idm_checker
  import idm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [PixW-1:0]   original_pixel_i,
  input  logic [PixW-1:0]   processed_pixel_i,
  input  logic              last_pixel_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CntW-1:0]   pixel_total_i,
  input  logic [CntW-1:0]   changed_total_i,
  input  logic [SqW-1:0]    squared_sum_i,
  input  logic [AbsW-1:0]   absolute_sum_i,
  input  logic [ChanW-1:0]  largest_difference_i,
  input  logic [FracW-1:0]  rms_fraction_i,
  input  logic [FracW-1:0]  mad_fraction_i,
  input  logic [BpW-1:0]    changed_basis_points_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam longint unsigned SquareMax = (64'd1 << SqW) - 64'd1;
  localparam longint unsigned AbsMax    = (64'd1 << AbsW) - 64'd1;
  localparam longint unsigned FracMax   = (64'd1 << FracW) - 64'd1;

  typedef struct {
    logic [CntW-1:0]  pixel_total;
    logic [CntW-1:0]  changed_total;
    logic [SqW-1:0]   squared_sum;
    logic [AbsW-1:0]  absolute_sum;
    logic [ChanW-1:0] largest;
    logic [FracW-1:0] rms;
    logic [FracW-1:0] mad;
    logic [BpW-1:0]   basis_points;
  } frame_metrics_t;

  frame_metrics_t expected_frames[$];
  frame_metrics_t closing_frame;
  frame_metrics_t oldest_frame;

  // Running frame totals
  longint unsigned  pixel_count;
  longint unsigned  changed_count;
  longint unsigned  square_acc;
  longint unsigned  abs_acc;
  logic [ChanW-1:0] largest_diff;

  function automatic logic [FracW-1:0] floor_root(logic [31:0] v);
    logic [FracW-1:0] res;
    logic [FracW-1:0] trial;
    int               b;
    res = '0;
    for (b = FracW - 1; b >= 0; b--) begin
      trial = res | (FracW'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(v)) res = trial;
    end
    return res;
  endfunction

  task automatic clear_frame();
    pixel_count   = 0;
    changed_count = 0;
    square_acc    = 0;
    abs_acc       = 0;
    largest_diff  = '0;
  endtask

  task automatic add_pixel(logic [PixW-1:0] orig, logic [PixW-1:0] proc);
    logic [ChanW-1:0] ch_o;
    logic [ChanW-1:0] ch_p;
    logic [ChanW-1:0] diff;
    logic [ChanW-1:0] peak;
    longint unsigned  sq;
    longint unsigned  ab;
    int               c;
    // Drop pixels past the frame limit entirely
    if (pixel_count < 64'(PIX_LIMIT)) begin
      peak = '0;
      sq   = 0;
      ab   = 0;
      for (c = 0; c < NumChan; c++) begin
        ch_o = orig[ChanW*c +: ChanW];
        ch_p = proc[ChanW*c +: ChanW];
        diff = (ch_o > ch_p) ? ch_o - ch_p : ch_p - ch_o;
        if (diff > peak) peak = diff;
        sq += 64'(diff) * 64'(diff);
        ab += 64'(diff);
      end
      pixel_count++;
      if (peak != 0) changed_count++;
      if (peak > largest_diff) largest_diff = peak;
      square_acc = (square_acc + sq > SquareMax) ? SquareMax : square_acc + sq;
      abs_acc    = (abs_acc + ab > AbsMax) ? AbsMax : abs_acc + ab;
    end
  endtask

  task automatic close_frame(output frame_metrics_t m);
    longint unsigned n;
    longint unsigned den;
    longint unsigned mad_q;
    longint unsigned bp_q;
    logic [127:0]    frac;
    n   = (pixel_count != 0) ? pixel_count : 1;
    den = 64'(RmsScale) * n;
    if (square_acc / den != 0) begin
      m.rms = FracW'(FracMax);
    end else begin
      frac  = (128'(square_acc) << 32) / 128'(den);
      m.rms = floor_root(frac[31:0]);
    end
    mad_q = (abs_acc << FracW) / (64'(MadScale) * n);
    m.mad = (mad_q > FracMax) ? FracW'(FracMax) : FracW'(mad_q);
    bp_q  = (changed_count * 64'(BpScale)) / n;
    m.basis_points  = (bp_q > 64'(BpScale)) ? BP_FULL : BpW'(bp_q);
    m.pixel_total   = CntW'(pixel_count);
    m.changed_total = CntW'(changed_count);
    m.squared_sum   = SqW'(square_acc);
    m.absolute_sum  = AbsW'(abs_acc);
    m.largest       = largest_diff;
    clear_frame();
  endtask

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      expected_frames.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        add_pixel(original_pixel_i, processed_pixel_i);
        if (last_pixel_i) begin
          close_frame(closing_frame);
          expected_frames.push_back(closing_frame);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: result with no frame closed, expected none, got pixel_total %0d",
                   $time, pixel_total_i);
          fail_count_o++;
        end else begin
          oldest_frame = expected_frames.pop_front();
          check_field("pixel_total", oldest_frame.pixel_total, pixel_total_i);
          check_field("changed_total", oldest_frame.changed_total, changed_total_i);
          check_field("squared_sum", oldest_frame.squared_sum, squared_sum_i);
          check_field("absolute_sum", oldest_frame.absolute_sum, absolute_sum_i);
          check_field("largest_difference", oldest_frame.largest, largest_difference_i);
          check_field("rms_fraction", oldest_frame.rms, rms_fraction_i);
          check_field("mad_fraction", oldest_frame.mad, mad_fraction_i);
          check_field("changed_basis_points", oldest_frame.basis_points,
                      changed_basis_points_i);
        end
      end
      pending_o = expected_frames.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import idm_pkg::*;

  localparam int HoldOffCycles = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PixW-1:0]   original_pixel = '0;
  logic [PixW-1:0]   processed_pixel = '0;
  logic              last_pixel = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CntW-1:0]   pixel_total;
  logic [CntW-1:0]   changed_total;
  logic [SqW-1:0]    squared_sum;
  logic [AbsW-1:0]   absolute_sum;
  logic [ChanW-1:0]  largest_difference;
  logic [FracW-1:0]  rms_fraction;
  logic [FracW-1:0]  mad_fraction;
  logic [BpW-1:0]    changed_basis_points;
  int                fail_count;
  int                frames_pending;

  int                sender_idle_pct = 0;
  int                receiver_stall_pct = 0;
  bit                holdoff_armed = 1'b0;

  always #10 clk = ~clk;

  image_difference_metrics dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .original_pixel_i       (original_pixel),
    .processed_pixel_i      (processed_pixel),
    .last_pixel_i           (last_pixel),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .pixel_total_o          (pixel_total),
    .changed_total_o        (changed_total),
    .squared_sum_o          (squared_sum),
    .absolute_sum_o         (absolute_sum),
    .largest_difference_o   (largest_difference),
    .rms_fraction_o         (rms_fraction),
    .mad_fraction_o         (mad_fraction),
    .changed_basis_points_o (changed_basis_points)
  );

  idm_checker metrics_check (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_ready_i             (in_ready),
    .original_pixel_i       (original_pixel),
    .processed_pixel_i      (processed_pixel),
    .last_pixel_i           (last_pixel),
    .out_valid_i            (out_valid),
    .out_ready_i            (out_ready),
    .pixel_total_i          (pixel_total),
    .changed_total_i        (changed_total),
    .squared_sum_i          (squared_sum),
    .absolute_sum_i         (absolute_sum),
    .largest_difference_i   (largest_difference),
    .rms_fraction_i         (rms_fraction),
    .mad_fraction_i         (mad_fraction),
    .changed_basis_points_i (changed_basis_points),
    .fail_count_o           (fail_count),
    .pending_o              (frames_pending)
  );

  // Receiver: random stalls, or a long hold-off when armed
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_armed) begin
        repeat (HoldOffCycles) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
        holdoff_armed = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one pixel pair at a falling edge and hold it until the transfer
  task automatic send_pixel(logic [PixW-1:0] orig, logic [PixW-1:0] proc, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    original_pixel  <= orig;
    processed_pixel <= proc;
    last_pixel      <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // style 0: fully random, 1: near-equal, 2: equal colors, 3: channels at 0 or 255
  task automatic make_pair(int style, output logic [PixW-1:0] orig,
                           output logic [PixW-1:0] proc);
    int c;
    int base;
    int delta;
    orig = $urandom;
    proc = $urandom;
    for (c = 0; c < NumChan; c++) begin
      case (style)
        1: begin
          base  = $urandom_range(255);
          delta = $urandom_range(3);
          orig[ChanW*c +: ChanW] = ChanW'(base);
          if ($urandom_range(1) == 1)
            proc[ChanW*c +: ChanW] = ChanW'((base + delta > 255) ? 255 : base + delta);
          else
            proc[ChanW*c +: ChanW] = ChanW'((base < delta) ? 0 : base - delta);
        end
        2: begin
          proc[ChanW*c +: ChanW] = orig[ChanW*c +: ChanW];
        end
        3: begin
          orig[ChanW*c +: ChanW] = {ChanW{$urandom_range(1) == 1}};
          proc[ChanW*c +: ChanW] = {ChanW{$urandom_range(1) == 1}};
        end
        default: ;
      endcase
    end
  endtask

  task automatic send_frame(int len);
    logic [PixW-1:0] orig;
    logic [PixW-1:0] proc;
    int              frame_style;
    int              i;
    frame_style = $urandom_range(5);
    for (i = 0; i < len; i++) begin
      make_pair((frame_style > 3) ? $urandom_range(3) : frame_style, orig, proc);
      send_pixel(orig, proc, i == len - 1);
    end
  endtask

  // Mostly short frames, now and then a longer one
  task automatic run_phase(int items, int idle_pct, int stall_pct);
    int sent;
    int len;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 12);
      send_frame(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames
    send_pixel(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_pixel(32'h0000_0000, 32'h00FF_FFFF, 1'b1);
    send_pixel(32'hFF00_0000, 32'h0000_0000, 1'b1);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_pixel(32'h0000_0001, 32'h0000_0000, 1'b0);
    send_pixel(32'h0000_FF00, 32'h0000_0000, 1'b0);
    send_pixel(32'h00FF_0000, 32'h0000_0000, 1'b1);
    send_pixel(32'h0010_2030, 32'h0030_2010, 1'b0);
    send_pixel(32'h8012_3456, 32'h7F12_3456, 1'b0);
    send_pixel(32'h0000_0000, 32'h0001_0101, 1'b0);
    send_pixel(32'h00FE_FEFE, 32'h00FF_FFFF, 1'b1);
    send_pixel(32'h00AA_AA55, 32'h0055_55AA, 1'b0);
    send_pixel(32'h0080_8080, 32'h0080_8080, 1'b0);
    send_pixel(32'h0000_00FF, 32'h0000_0000, 1'b0);
    send_pixel(32'h1234_5678, 32'h1234_5678, 1'b1);
    send_pixel(32'h5A00_0000, 32'hA500_0000, 1'b0);
    send_pixel(32'h0001_0000, 32'h0000_0000, 1'b1);

    run_phase(340, 0, 0);
    run_phase(340, 47, 0);
    // Hold the output while the sender keeps pushing, so the block backs up
    holdoff_armed = 1'b1;
    run_phase(80, 0, 0);
    run_phase(340, 0, 47);
    run_phase(340, 9, 9);

    in_valid <= 1'b0;
    wait (frames_pending == 0);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
